FILE: rtl/per_lane_reorder_buffer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-lane reorder buffer
// Clocked, reset-qualified property checks; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef PER_LANE_REORDER_BUFFER_UNIT_ASSERT_SVH
`define PER_LANE_REORDER_BUFFER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PLRB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PLRB_ASSERT_IMP(lbl, ante, cons, msg) `PLRB_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define PLRB_ASSERT(lbl, prop, msg)
`define PLRB_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/plrb_pkg.sv
// ----------------------------------------------------------------------------
// plrb_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plrb_pkg;

	localparam int ORD_W       = 16;
	localparam int HANDLE_W    = 16;
	localparam int TIME_W      = 32;
	localparam int LANE_W      = 2;
	localparam int OP_W        = 2;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 40;

	localparam int NUM_LANES_DEF  = 4;
	localparam int HOLD_DEPTH_DEF = 8;

	localparam logic [ORD_W-1:0] ORD_HALF = 16'h8000;

	localparam logic [CFG_W-1:0]  GAP_TIMEOUT_RST      = 16'd200;
	localparam logic [CFG_W-1:0]  LONG_GAP_TIMEOUT_RST = 16'd30000;
	localparam logic [LANE_W-1:0] LONG_GAP_LANE_RST    = 2'd1;

	localparam logic [OP_W-1:0] OP_EVENT  = 2'd0;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_GAP_TIMEOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_GAP_LANE    = 2'd2;

	typedef struct packed {
		logic load;
		logic lane_start;
		logic clear_lane;
		logic slot_clr;
		logic slot_inc;
		logic rd;
		logic emit_in;
		logic skip;
		logic set_skip;
		logic exp_inc;
		logic exp_ord1;
		logic exp_best;
		logic take;
		logic found_set;
		logic found_clr;
		logic best_clr;
		logic best_upd;
		logic gap_off;
		logic gap_off_if_empty;
		logic hold_write;
		logic tick_lane_clr;
		logic tick_lane_inc;
		logic flush;
	} plrb_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic lane_ok;
		logic behind;
		logic at_exp;
		logic fits;
		logic free_any;
		logic slot_valid;
		logic slot_last;
		logic rd_eq_exp;
		logic rd_eq_ord;
		logic rd_better;
		logic cnt_zero;
		logic found;
		logic have;
		logic tick_due;
		logic lane_last;
		logic can_push;
		logic pend_valid;
	} plrb_sts_t;

endpackage

FILE: rtl/plrb_datapath.sv
// ----------------------------------------------------------------------------
// plrb_datapath
// Lane state, hold store, scan registers and the two-deep result buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plrb_datapath import plrb_pkg::*; #(
	parameter int NUM_LANES  = NUM_LANES_DEF,
	parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [OP_W-1:0]      in_opcode,
	input  logic [LANE_W-1:0]    in_lane,
	input  logic [ORD_W-1:0]     in_order,
	input  logic [HANDLE_W-1:0]  in_handle,
	input  logic                 in_fits,
	input  logic [TIME_W-1:0]    in_time,
	input  plrb_cmd_t            cmd,
	output plrb_sts_t            sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [HANDLE_W-1:0]  out_handle,
	output logic [LANE_W-1:0]    out_lane,
	output logic [ORD_W-1:0]     out_order,
	output logic                 out_skip,
	output logic                 out_last
);

	localparam int LW    = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
	localparam int SW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
	localparam int CW    = $clog2(HOLD_DEPTH + 1);
	localparam int DEPTH = NUM_LANES * HOLD_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef struct packed {
		logic [ORD_W-1:0]    order;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	logic [CFG_W-1:0]  gap_to_q, long_to_q;
	logic [LANE_W-1:0] long_lane_q;

	logic [OP_W-1:0]     op_q;
	logic                lane_ok_q;
	logic [LW-1:0]       lane_q;
	logic [ORD_W-1:0]    ord_q;
	logic [HANDLE_W-1:0] handle_q;
	logic                fits_q;
	logic [TIME_W-1:0]   now_q;

	logic [ORD_W-1:0]  exp_q     [NUM_LANES];
	logic              started_q [NUM_LANES];
	logic [CW-1:0]     cnt_q     [NUM_LANES];
	logic              gap_on_q  [NUM_LANES];
	logic [TIME_W-1:0] gap_t0_q  [NUM_LANES];
	logic              valid_q   [NUM_LANES][HOLD_DEPTH];

	entry_t mem_q [DEPTH];
	entry_t rd_q;

	logic [SW-1:0]    slot_q;
	logic             found_q, skip_q, have_q;
	logic [ORD_W-1:0] best_q;

	logic                pend_valid_q;
	entry_t              pend_q;
	logic [LANE_W-1:0]   pend_lane_q;
	logic                pend_skip_q;

	logic                out_valid_q, out_skip_q, out_last_q;
	entry_t              out_q;
	logic [LANE_W-1:0]   out_lane_q;

	logic          free_any;
	logic [SW-1:0] free_idx;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [ORD_W-1:0]  cur_exp, diff;
	logic [CFG_W-1:0]  wait_lim;
	logic [TIME_W-1:0] elapsed;
	logic          out_free, push, load_out;
	entry_t        push_data;

	// first free slot of the current lane, lowest index wins
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = HOLD_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[lane_q][i]) begin
				free_any = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	assign rd_addr  = AW'(lane_q) * AW'(HOLD_DEPTH) + AW'(slot_q);
	assign wr_addr  = AW'(lane_q) * AW'(HOLD_DEPTH) + AW'(free_idx);
	assign cur_exp  = exp_q[lane_q];
	assign diff     = ord_q - cur_exp;
	assign wait_lim = (32'(lane_q) == 32'(long_lane_q)) ? long_to_q : gap_to_q;
	assign elapsed  = now_q - gap_t0_q[lane_q];

	assign out_free  = !out_valid_q || out_ready;
	assign push      = cmd.emit_in || cmd.take;
	assign load_out  = (push || cmd.flush) && pend_valid_q;
	assign push_data = cmd.take ? rd_q : '{order: ord_q, handle: handle_q};

	always_comb begin
		sts            = '0;
		sts.op         = op_q;
		sts.lane_ok    = lane_ok_q;
		sts.behind     = diff >= ORD_HALF;
		sts.at_exp     = diff == '0;
		sts.fits       = fits_q;
		sts.free_any   = free_any;
		sts.slot_valid = valid_q[lane_q][slot_q];
		sts.slot_last  = slot_q == SW'(HOLD_DEPTH - 1);
		sts.rd_eq_exp  = rd_q.order == cur_exp;
		sts.rd_eq_ord  = rd_q.order == ord_q;
		sts.rd_better  = !have_q || ((rd_q.order - best_q) >= ORD_HALF);
		sts.cnt_zero   = cnt_q[lane_q] == '0;
		sts.found      = found_q;
		sts.have       = have_q;
		sts.tick_due   = (cnt_q[lane_q] != '0) && gap_on_q[lane_q]
		                 && (elapsed >= {{(TIME_W-CFG_W){1'b0}}, wait_lim});
		sts.lane_last  = lane_q == LW'(NUM_LANES - 1);
		sts.can_push   = !pend_valid_q || out_free;
		sts.pend_valid = pend_valid_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_to_q     <= GAP_TIMEOUT_RST;
			long_to_q    <= LONG_GAP_TIMEOUT_RST;
			long_lane_q  <= LONG_GAP_LANE_RST;
			op_q         <= OP_EVENT;
			lane_ok_q    <= 1'b0;
			lane_q       <= '0;
			slot_q       <= '0;
			found_q      <= 1'b0;
			skip_q       <= 1'b0;
			have_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int l = 0; l < NUM_LANES; l++) begin
				exp_q[l]     <= '0;
				started_q[l] <= 1'b0;
				cnt_q[l]     <= '0;
				gap_on_q[l]  <= 1'b0;
				for (int s = 0; s < HOLD_DEPTH; s++) valid_q[l][s] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GAP_TIMEOUT:      gap_to_q    <= cfg_data;
					REG_LONG_GAP_TIMEOUT: long_to_q   <= cfg_data;
					REG_LONG_GAP_LANE:    long_lane_q <= cfg_data[LANE_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				op_q      <= in_opcode;
				lane_ok_q <= 32'(in_lane) < 32'(NUM_LANES);
				lane_q    <= LW'(in_lane);
			end
			if (cmd.tick_lane_clr) lane_q <= '0;
			if (cmd.tick_lane_inc) lane_q <= lane_q + 1'b1;

			if (cmd.slot_clr) slot_q <= '0;
			if (cmd.slot_inc) slot_q <= slot_q + 1'b1;

			if (cmd.found_set || cmd.take) found_q <= 1'b1;
			if (cmd.found_clr) found_q <= 1'b0;
			if (cmd.emit_in || cmd.set_skip) skip_q <= cmd.skip;
			if (cmd.best_clr) have_q <= 1'b0;
			if (cmd.best_upd) have_q <= 1'b1;

			if (cmd.lane_start && !started_q[lane_q]) begin
				started_q[lane_q] <= 1'b1;
				exp_q[lane_q]     <= ord_q;
			end
			if (cmd.exp_inc || cmd.take) exp_q[lane_q] <= cur_exp + 1'b1;
			if (cmd.exp_ord1) exp_q[lane_q] <= ord_q + 1'b1;
			if (cmd.exp_best) exp_q[lane_q] <= best_q;
			if (cmd.take) begin
				valid_q[lane_q][slot_q] <= 1'b0;
				cnt_q[lane_q]           <= cnt_q[lane_q] - 1'b1;
			end
			if (cmd.hold_write) begin
				valid_q[lane_q][free_idx] <= 1'b1;
				cnt_q[lane_q]             <= cnt_q[lane_q] + 1'b1;
				gap_on_q[lane_q]          <= 1'b1;
			end
			if (cmd.gap_off) gap_on_q[lane_q] <= 1'b0;
			if (cmd.gap_off_if_empty && cnt_q[lane_q] == '0) gap_on_q[lane_q] <= 1'b0;
			if (cmd.clear_lane) begin
				exp_q[lane_q]     <= '0;
				started_q[lane_q] <= 1'b0;
				cnt_q[lane_q]     <= '0;
				gap_on_q[lane_q]  <= 1'b0;
				for (int s = 0; s < HOLD_DEPTH; s++) valid_q[lane_q][s] <= 1'b0;
			end

			if (push) pend_valid_q <= 1'b1;
			else if (cmd.flush) pend_valid_q <= 1'b0;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload: input word, hold store, scan and result words
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ord_q    <= in_order;
			handle_q <= in_handle;
			fits_q   <= in_fits;
			now_q    <= in_time;
		end
		if (cmd.hold_write) begin
			mem_q[wr_addr] <= '{order: ord_q, handle: handle_q};
			if (!gap_on_q[lane_q]) gap_t0_q[lane_q] <= now_q;
		end
		if (cmd.rd) rd_q <= mem_q[rd_addr];
		if (cmd.best_upd) best_q <= rd_q.order;
		if (push) begin
			pend_q      <= push_data;
			pend_lane_q <= LANE_W'(lane_q);
			pend_skip_q <= cmd.take ? skip_q : cmd.skip;
		end
		if (load_out) begin
			out_q      <= pend_q;
			out_lane_q <= pend_lane_q;
			out_skip_q <= pend_skip_q;
			out_last_q <= !push;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_handle = out_q.handle;
	assign out_lane   = out_lane_q;
	assign out_order  = out_q.order;
	assign out_skip   = out_skip_q;
	assign out_last   = out_last_q;

endmodule

FILE: rtl/plrb_controller.sv
// ----------------------------------------------------------------------------
// plrb_controller
// Sequencer for event, tick and clear words: slot scans, drain and flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plrb_controller import plrb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  plrb_sts_t sts,
	output plrb_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_START, ST_CHECK, ST_EMIT, ST_SKIP, ST_DUP_RD, ST_DUP_CMP,
		ST_HOLD, ST_DR_START, ST_DR_RD, ST_DR_CMP, ST_DR_END, ST_TK_LANE,
		ST_TK_RD, ST_TK_CMP, ST_TK_SET, ST_TK_NEXT, ST_FINISH
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				state_d = ST_FINISH;
				unique case (sts.op)
					OP_EVENT: if (sts.lane_ok) begin
						cmd.lane_start = 1'b1;
						state_d        = ST_CHECK;
					end
					OP_TICK: begin
						cmd.tick_lane_clr = 1'b1;
						state_d           = ST_TK_LANE;
					end
					OP_CLEAR: cmd.clear_lane = sts.lane_ok;
					default: ;
				endcase
			end
			ST_CHECK: begin
				if (sts.behind) state_d = ST_FINISH;
				else if (sts.at_exp) state_d = ST_EMIT;
				else if (sts.fits) begin
					cmd.slot_clr = 1'b1;
					state_d      = ST_DUP_RD;
				end else state_d = ST_SKIP;
			end
			ST_EMIT: if (sts.can_push) begin
				cmd.emit_in   = 1'b1;
				cmd.exp_inc   = 1'b1;
				cmd.found_set = 1'b1;
				state_d       = ST_DR_START;
			end
			ST_SKIP: if (sts.can_push) begin
				cmd.emit_in   = 1'b1;
				cmd.skip      = 1'b1;
				cmd.exp_ord1  = 1'b1;
				cmd.found_set = 1'b1;
				state_d       = ST_DR_START;
			end
			ST_DUP_RD: begin
				if (sts.slot_valid) begin
					cmd.rd  = 1'b1;
					state_d = ST_DUP_CMP;
				end else if (sts.slot_last) state_d = ST_HOLD;
				else cmd.slot_inc = 1'b1;
			end
			ST_DUP_CMP: begin
				if (sts.rd_eq_ord) state_d = ST_FINISH;
				else if (sts.slot_last) state_d = ST_HOLD;
				else begin
					cmd.slot_inc = 1'b1;
					state_d      = ST_DUP_RD;
				end
			end
			ST_HOLD: begin
				// no duplicate found: hold it, or skip ahead when every slot is busy
				if (sts.free_any) begin
					cmd.hold_write = 1'b1;
					state_d        = ST_FINISH;
				end else state_d = ST_SKIP;
			end
			ST_DR_START: begin
				if (!sts.found || sts.cnt_zero) state_d = ST_DR_END;
				else begin
					cmd.found_clr = 1'b1;
					cmd.slot_clr  = 1'b1;
					state_d       = ST_DR_RD;
				end
			end
			ST_DR_RD: begin
				if (sts.slot_valid) begin
					cmd.rd  = 1'b1;
					state_d = ST_DR_CMP;
				end else if (sts.slot_last) state_d = ST_DR_START;
				else cmd.slot_inc = 1'b1;
			end
			ST_DR_CMP: begin
				// a match waits for room in the result buffer before moving on
				if (!sts.rd_eq_exp || sts.can_push) begin
					cmd.take = sts.rd_eq_exp;
					if (sts.slot_last) state_d = ST_DR_START;
					else begin
						cmd.slot_inc = 1'b1;
						state_d      = ST_DR_RD;
					end
				end
			end
			ST_DR_END: begin
				cmd.gap_off_if_empty = 1'b1;
				state_d = (sts.op == OP_TICK) ? ST_TK_NEXT : ST_FINISH;
			end
			ST_TK_LANE: begin
				if (sts.tick_due) begin
					cmd.slot_clr = 1'b1;
					cmd.best_clr = 1'b1;
					state_d      = ST_TK_RD;
				end else state_d = ST_TK_NEXT;
			end
			ST_TK_RD: begin
				if (sts.slot_valid) begin
					cmd.rd  = 1'b1;
					state_d = ST_TK_CMP;
				end else if (sts.slot_last) state_d = ST_TK_SET;
				else cmd.slot_inc = 1'b1;
			end
			ST_TK_CMP: begin
				cmd.best_upd = sts.rd_better;
				if (sts.slot_last) state_d = ST_TK_SET;
				else begin
					cmd.slot_inc = 1'b1;
					state_d      = ST_TK_RD;
				end
			end
			ST_TK_SET: begin
				cmd.gap_off = 1'b1;
				if (sts.have) begin
					cmd.exp_best  = 1'b1;
					cmd.found_set = 1'b1;
					cmd.set_skip  = 1'b1;
					cmd.skip      = 1'b1;
					state_d       = ST_DR_START;
				end else state_d = ST_TK_NEXT;
			end
			ST_TK_NEXT: begin
				if (sts.lane_last) state_d = ST_FINISH;
				else begin
					cmd.tick_lane_inc = 1'b1;
					state_d           = ST_TK_LANE;
				end
			end
			ST_FINISH: if (sts.can_push) begin
				cmd.flush = 1'b1;
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

FILE: rtl/per_lane_reorder_buffer_unit.sv
// ----------------------------------------------------------------------------
// per_lane_reorder_buffer_unit
// Sequencing: each hold-slot scan steps through the HOLD_DEPTH slots in order and
//   reads each valid one; a drain repeats its pass while entries are taken, and a
//   stalled result output holds the sequence.
// Throughput: one word at a time; a tick scans every lane in turn.
// Reset: arst_n clears lane state, hold valid bits and control registers at once; payload words are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "per_lane_reorder_buffer_unit_assert.svh"

module per_lane_reorder_buffer_unit import plrb_pkg::*; #(
	parameter int NUM_LANES  = NUM_LANES_DEF,
	parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	// input words
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// lane_index[1:0], order_number[17:2], event_handle[33:18], fits_hold[34],
	// time_now[66:35], zero pad above
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// opcode[1:0]
	input  logic [OP_W-1:0]        s_tuser,
	// result words
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out_handle[15:0], out_lane[17:16], out_order[33:18], zero pad above
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// skipped_gap[0]
	output logic [0:0]             m_tuser,
	// last_of_run
	output logic                   m_tlast
);

	plrb_cmd_t cmd;
	plrb_sts_t sts;

	logic [HANDLE_W-1:0] out_handle;
	logic [LANE_W-1:0]   out_lane;
	logic [ORD_W-1:0]    out_order;
	logic                out_skip;

	// the controller walks the scan states; the datapath owns all storage
	plrb_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	plrb_datapath #(
		.NUM_LANES  (NUM_LANES),
		.HOLD_DEPTH (HOLD_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_opcode  (s_tuser),
		.in_lane    (s_tdata[1:0]),
		.in_order   (s_tdata[17:2]),
		.in_handle  (s_tdata[33:18]),
		.in_fits    (s_tdata[34]),
		.in_time    (s_tdata[66:35]),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_handle (out_handle),
		.out_lane   (out_lane),
		.out_order  (out_order),
		.out_skip   (out_skip),
		.out_last   (m_tlast)
	);

	// pack the result word, pad to whole bytes
	assign m_tdata = {6'b0, out_order, out_lane, out_handle};
	assign m_tuser = out_skip;

	// no result may still sit in the pending stage when a new word is taken
	`PLRB_ASSERT_IMP(a_idle_no_pend, s_tready, !sts.pend_valid, "pending result at idle")
	// a drained entry is only taken, or an input emitted, when the result buffer has room
	`PLRB_ASSERT_IMP(a_take_room, cmd.take || cmd.emit_in, sts.can_push, "emit without room")
	// a hold is only written into a free slot
	`PLRB_ASSERT_IMP(a_hold_free, cmd.hold_write, sts.free_any, "hold write with no free slot")

endmodule
